### src/glb_chunk_deframer_core_assert.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; each file that asserts includes it by name.
`ifndef GLB_CHUNK_DEFRAMER_CORE_ASSERT_SVH
`define GLB_CHUNK_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define GCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### src/gcd_pkg.sv
// Package for the binary glTF chunk deframer: constants, codes and payload types.
// Depends on nothing; used by the core.
package gcd_pkg;

    localparam logic [31:0] GlbMagic = 32'h4654_6C67;
    localparam logic [31:0] TypeJson = 32'h4E4F_534A;
    localparam logic [31:0] TypeBin  = 32'h004E_4942;

    localparam logic [4:0] MinFileBytes  = 5'd20;
    localparam logic [3:0] FileHdrBytes  = 4'd12;
    localparam logic [3:0] MagicBytes    = 4'd4;
    localparam logic [3:0] ChunkHdrBytes = 4'd8;
    localparam logic [2:0] ChunkHdrLast  = 3'(ChunkHdrBytes - 4'd1);

    localparam logic [1:0] KindJson    = 2'd0;
    localparam logic [1:0] KindBin     = 2'd1;
    localparam logic [1:0] KindVerdict = 2'd2;

    localparam logic [2:0] VerdictOk        = 3'd0;
    localparam logic [2:0] VerdictTooShort  = 3'd1;
    localparam logic [2:0] VerdictBadMagic  = 3'd2;
    localparam logic [2:0] VerdictTruncated = 3'd3;
    localparam logic [2:0] VerdictNoJson    = 3'd4;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = FifoPtrW + 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] payload_byte;
        logic       chunk_start;
        logic [2:0] verdict;
        logic       final_item;
    } t_out_item;

endpackage

### src/gcd_chan_if.sv
// Valid/ready channel interface carrying one request payload of type T.
// Depends on nothing; instantiated with the payload types of gcd_pkg.
interface gcd_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/glb_chunk_deframer_core.sv
// Binary glTF container deframer: one byte per request in, payload and verdict requests out.
// Depends on gcd_pkg, gcd_chan_if and glb_chunk_deframer_core_assert.svh.
//
// The block takes one file byte per clock cycle while i_in_chan.ready is high, and parses it
// in the same cycle. A result is offered on o_out_chan the cycle after its byte is accepted if
// the output queue is empty, and otherwise behind the requests already queued. JSON and BIN
// payload bytes leave as they arrive; the final byte of a file adds a verdict request after
// any payload request. Results pass through a four-entry output queue, and i_in_chan.ready
// stays high while at least two entries are free. With an output side that takes one request
// per cycle, the extra verdict request leaves two requests queued, so later results wait
// behind them. The input then stalls at most once per file.
// Payload of a chunk that is cut short has already gone out when the verdict reports it.
`include "glb_chunk_deframer_core_assert.svh"

module glb_chunk_deframer_core
    import gcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcd_chan_if.sink    i_in_chan,
    gcd_chan_if.source  o_out_chan
);

    localparam logic [FifoCntW-1:0] FifoRoomLimit = FifoCntW'(FifoDepth - 2);

    logic [3:0]  r_hdr_seen, n_hdr_seen;
    logic        r_magic_good, n_magic_good;
    logic [4:0]  r_total_seen, n_total_seen;
    logic [2:0]  r_chdr_bytes, n_chdr_bytes;
    logic [31:0] r_chunk_len, n_chunk_len;
    logic [31:0] r_chunk_type, n_chunk_type;
    logic [31:0] r_payload_left, n_payload_left;
    logic        r_in_payload, n_in_payload;
    logic        r_json_present, n_json_present;

    t_out_item              r_queue [FifoDepth];
    logic [FifoPtrW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [FifoCntW-1:0]    r_count;
    logic [FifoPtrW-1:0]    wr_ptr_second;

    logic        in_accept;
    logic        out_pop;
    logic [7:0]  in_byte;
    logic        in_eof;
    logic [31:0] magic_word;
    logic [4:0]  lane_base;
    logic [2:0]  verdict_code;
    t_out_item   push_item0, push_item1;
    logic [1:0]  push_cnt;

    assign in_byte   = i_in_chan.data.data_byte;
    assign in_eof    = i_in_chan.data.end_of_file;
    assign in_accept = i_in_chan.valid && i_in_chan.ready;
    assign out_pop   = o_out_chan.valid && o_out_chan.ready;

    assign i_in_chan.ready  = (r_count <= FifoRoomLimit);
    assign o_out_chan.valid = (r_count != '0);
    assign o_out_chan.data  = r_queue[r_rd_ptr];

    assign magic_word    = GlbMagic >> {r_hdr_seen[1:0], 3'b000};
    assign lane_base     = {r_chdr_bytes[1:0], 3'b000};
    assign wr_ptr_second = r_wr_ptr + 1'b1;

    always_comb begin
        n_hdr_seen     = r_hdr_seen;
        n_magic_good   = r_magic_good;
        n_total_seen   = r_total_seen;
        n_chdr_bytes   = r_chdr_bytes;
        n_chunk_len    = r_chunk_len;
        n_chunk_type   = r_chunk_type;
        n_payload_left = r_payload_left;
        n_in_payload   = r_in_payload;
        n_json_present = r_json_present;
        verdict_code   = VerdictOk;
        push_item0     = '0;
        push_item1     = '0;
        push_cnt       = 2'd0;

        if (in_accept) begin
            if (r_total_seen < MinFileBytes) begin
                n_total_seen = r_total_seen + 5'd1;
            end

            if (r_hdr_seen < FileHdrBytes) begin
                if ((r_hdr_seen < MagicBytes) && (in_byte != magic_word[7:0])) begin
                    n_magic_good = 1'b0;
                end
                n_hdr_seen = r_hdr_seen + 4'd1;
            end else if (r_magic_good) begin
                if (r_in_payload) begin
                    if ((r_chunk_type == TypeJson) || (r_chunk_type == TypeBin)) begin
                        push_item0.item_kind    = (r_chunk_type == TypeJson) ? KindJson
                                                                             : KindBin;
                        push_item0.payload_byte = in_byte;
                        push_item0.chunk_start  = (r_payload_left == r_chunk_len);
                        push_cnt                = 2'd1;
                    end
                    n_payload_left = r_payload_left - 32'd1;
                    if (r_payload_left == 32'd1) begin
                        n_in_payload = 1'b0;
                    end
                end else begin
                    if (!r_chdr_bytes[2]) begin
                        if (r_chdr_bytes[1:0] == 2'd0) begin
                            n_chunk_len = '0;
                        end
                        n_chunk_len[lane_base +: 8] = in_byte;
                    end else begin
                        if (r_chdr_bytes[1:0] == 2'd0) begin
                            n_chunk_type = '0;
                        end
                        n_chunk_type[lane_base +: 8] = in_byte;
                    end
                    n_chdr_bytes = r_chdr_bytes + 3'd1;
                    if (r_chdr_bytes == ChunkHdrLast) begin
                        n_payload_left = n_chunk_len;
                        n_in_payload   = (n_chunk_len != '0);
                        if (n_chunk_type == TypeJson) begin
                            n_json_present = (n_chunk_len != '0);
                        end
                    end
                end
            end

            if (in_eof) begin
                if (n_total_seen < MinFileBytes) begin
                    verdict_code = VerdictTooShort;
                end else if (!n_magic_good) begin
                    verdict_code = VerdictBadMagic;
                end else if (n_in_payload) begin
                    verdict_code = VerdictTruncated;
                end else if (!n_json_present) begin
                    verdict_code = VerdictNoJson;
                end else begin
                    verdict_code = VerdictOk;
                end

                if (push_cnt == 2'd1) begin
                    push_item1.item_kind  = KindVerdict;
                    push_item1.verdict    = verdict_code;
                    push_item1.final_item = 1'b1;
                    push_cnt              = 2'd2;
                end else begin
                    push_item0.item_kind  = KindVerdict;
                    push_item0.verdict    = verdict_code;
                    push_item0.final_item = 1'b1;
                    push_cnt              = 2'd1;
                end

                n_hdr_seen     = '0;
                n_magic_good   = 1'b1;
                n_total_seen   = '0;
                n_chdr_bytes   = '0;
                n_chunk_len    = '0;
                n_chunk_type   = '0;
                n_payload_left = '0;
                n_in_payload   = 1'b0;
                n_json_present = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_seen     <= '0;
            r_magic_good   <= 1'b1;
            r_total_seen   <= '0;
            r_chdr_bytes   <= '0;
            r_chunk_len    <= '0;
            r_chunk_type   <= '0;
            r_payload_left <= '0;
            r_in_payload   <= 1'b0;
            r_json_present <= 1'b0;
        end else begin
            r_hdr_seen     <= n_hdr_seen;
            r_magic_good   <= n_magic_good;
            r_total_seen   <= n_total_seen;
            r_chdr_bytes   <= n_chdr_bytes;
            r_chunk_len    <= n_chunk_len;
            r_chunk_type   <= n_chunk_type;
            r_payload_left <= n_payload_left;
            r_in_payload   <= n_in_payload;
            r_json_present <= n_json_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FifoPtrW'(push_cnt);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FifoCntW'(push_cnt) - FifoCntW'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= push_item0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[wr_ptr_second] <= push_item1;
        end
    end

    `GCD_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= FifoCntW'(FifoDepth))
    `GCD_ASSERT_IMP(a_payload_nonzero, i_clk, i_rst_n, r_in_payload, r_payload_left != '0)
    `GCD_ASSERT_IMP(a_no_payload_in_header, i_clk, i_rst_n, r_hdr_seen < FileHdrBytes, !r_in_payload && (r_chdr_bytes == '0))
    `GCD_ASSERT_NXT(a_eof_restarts, i_clk, i_rst_n, in_accept && in_eof, (r_hdr_seen == '0) && (r_total_seen == '0) && r_magic_good && !r_json_present)

endmodule
